@@ src/csvefs_pkg.sv @@
`default_nettype none
package csvefs_pkg;

	localparam int OFFSET_W  = 24;
	localparam int KIND_W    = 2;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_SEP   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRAIL = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_COL_SEP_BYTES  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COL_SEP_LENGTH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LINE_DLM_BYTES = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LINE_DLM_LEN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ENCLOSE_CHAR   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CHAR    = 3'd5;

	typedef struct packed {
		logic [31:0] column_sep_bytes;
		logic [2:0]  column_sep_length;
		logic [31:0] line_delim_bytes;
		logic [2:0]  line_delim_length;
		logic [7:0]  enclose_char;
		logic [7:0]  escape_char;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [OFFSET_W-1:0] offset;
		logic                saturated;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

@@ src/csvefs_cfg.sv @@
`default_nettype none
module csvefs_cfg
	import csvefs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.column_sep_bytes  <= 32'd44;
			cfg.column_sep_length <= 3'd1;
			cfg.line_delim_bytes  <= 32'd10;
			cfg.line_delim_length <= 3'd1;
			cfg.enclose_char      <= 8'd34;
			cfg.escape_char       <= 8'd92;
		end else if (wr) begin
			case (idx)
				REG_COL_SEP_BYTES:  cfg.column_sep_bytes  <= pwdata;
				REG_COL_SEP_LENGTH: cfg.column_sep_length <= pwdata[2:0];
				REG_LINE_DLM_BYTES: cfg.line_delim_bytes  <= pwdata;
				REG_LINE_DLM_LEN:   cfg.line_delim_length <= pwdata[2:0];
				REG_ENCLOSE_CHAR:   cfg.enclose_char      <= pwdata[7:0];
				REG_ESCAPE_CHAR:    cfg.escape_char       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COL_SEP_BYTES:  prdata = cfg.column_sep_bytes;
			REG_COL_SEP_LENGTH: prdata = {29'd0, cfg.column_sep_length};
			REG_LINE_DLM_BYTES: prdata = cfg.line_delim_bytes;
			REG_LINE_DLM_LEN:   prdata = {29'd0, cfg.line_delim_length};
			REG_ENCLOSE_CHAR:   prdata = {24'd0, cfg.enclose_char};
			REG_ESCAPE_CHAR:    prdata = {24'd0, cfg.escape_char};
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ src/csvefs_core.sv @@
`default_nettype none
module csvefs_core
	import csvefs_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 4,
	parameter int POSITION_BITS     = 24
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       go,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_data,
	output res_t            res0,
	output res_t            res1,
	output logic [1:0]      res_cnt
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int EXT_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

	localparam logic [2:0] ST_START  = 3'd0;
	localparam logic [2:0] ST_NORMAL = 3'd1;
	localparam logic [2:0] ST_QUOTED = 3'd2;
	localparam logic [2:0] ST_CLOSED = 3'd3;
	localparam logic [2:0] ST_SKIP   = 3'd4;

	typedef logic [MAX_PATTERN_BYTES-1:0][7:0] win_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [2:0] r);
		logic [LEN_W-1:0] l;
		if (r == 3'd0) l = LEN_W'(1);
		else if (32'(r) > MAX_PATTERN_BYTES) l = LEN_MAX;
		else l = LEN_W'(r);
		return l;
	endfunction

	function automatic logic [7:0] pat_byte(input logic [31:0] pat, input int k);
		logic [7:0] b;
		b = 8'd0;
		for (int i = 0; i < 4; i++) begin
			if (i == k) b = pat[8*i +: 8];
		end
		return b;
	endfunction

	function automatic logic win_match(input win_t w, input logic [31:0] pat,
		input logic [LEN_W-1:0] len);
		logic m;
		logic ok;
		m = 1'b0;
		for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
			ok = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (w[l-1-k] != pat_byte(pat, k)) ok = 1'b0;
			end
			if (LEN_W'(l) == len) m = ok;
		end
		return m;
	endfunction

	function automatic res_t make_res(input logic [KIND_W-1:0] kind,
		input logic [POSITION_BITS-1:0] v, input logic sat);
		res_t r;
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		r.kind = kind;
		r.last = 1'b0;
		if (ext > EXT_W'(OFFSET_MAX)) begin
			r.offset    = OFFSET_MAX;
			r.saturated = 1'b1;
		end else begin
			r.offset    = OFFSET_W'(ext);
			r.saturated = sat;
		end
		return r;
	endfunction

	logic [2:0]               st_q, st_n;
	logic                     esc_q, esc_n;
	logic [POSITION_BITS-1:0] pos_q, pos_inc;
	logic                     ovf_q, ovf_inc;
	win_t                     win_q, win_n;
	logic [LEN_W-1:0]         fmf_q, fmf_inc, fmf_n;
	logic [LEN_W-1:0]         dfl_q, dfl_inc, dfl_n;
	logic [LEN_W-1:0]         slen, dlen;
	logic                     sep_win, dlm_hit, sep_emit, pos_full;
	logic [POSITION_BITS-1:0] sep_off, dlm_off;
	res_t                     r_sep, r_dlm, r_eod;

	always_comb begin
		win_n[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++) win_n[i] = win_q[i-1];

		slen    = eff_len(cfg.column_sep_length);
		dlen    = eff_len(cfg.line_delim_length);
		fmf_inc = (fmf_q < LEN_MAX) ? fmf_q + 1'b1 : fmf_q;
		dfl_inc = (dfl_q < LEN_MAX) ? dfl_q + 1'b1 : dfl_q;

		sep_win = win_match(win_n, cfg.column_sep_bytes, slen);
		dlm_hit = (st_q != ST_QUOTED) && (dfl_inc >= dlen) &&
			win_match(win_n, cfg.line_delim_bytes, dlen);

		pos_full = &pos_q;
		pos_inc  = pos_full ? pos_q : pos_q + 1'b1;
		ovf_inc  = ovf_q | pos_full;
		sep_off  = pos_q - POSITION_BITS'(slen - 1'b1);
		dlm_off  = pos_q - POSITION_BITS'(dlen - 1'b1);

		st_n     = st_q;
		esc_n    = esc_q;
		fmf_n    = fmf_inc;
		dfl_n    = dfl_inc;
		sep_emit = 1'b0;
		case (st_q)
			ST_START: begin
				if (data_byte == cfg.enclose_char) begin
					st_n  = ST_QUOTED;
					esc_n = 1'b0;
				end else begin
					st_n = ST_NORMAL;
				end
			end
			ST_QUOTED: begin
				if (data_byte == cfg.escape_char) begin
					esc_n = !esc_q;
				end else if (esc_q) begin
					esc_n = 1'b0;
				end else if (data_byte == cfg.enclose_char) begin
					st_n  = ST_CLOSED;
					fmf_n = '0;
					dfl_n = '0;
				end
			end
			ST_CLOSED: begin
				if (fmf_inc >= slen) begin
					if (sep_win) begin
						sep_emit = 1'b1;
						fmf_n    = '0;
						st_n     = ST_START;
					end else begin
						st_n = ST_SKIP;
					end
				end
			end
			ST_NORMAL: ;
			default: st_n = ST_SKIP;
		endcase
		if (st_n == ST_NORMAL && fmf_inc >= slen && sep_win) begin
			sep_emit = 1'b1;
			fmf_n    = '0;
			st_n     = ST_START;
		end

		r_sep = make_res(KIND_SEP, sep_off, ovf_q);
		r_dlm = make_res(KIND_LINE, dlm_off, ovf_q);
		r_eod = make_res(KIND_TRAIL, pos_inc, ovf_inc);

		if (dlm_hit) begin
			res0      = r_dlm;
			res0.last = 1'b1;
			res1      = r_eod;
			res1.last = 1'b1;
			res_cnt   = 2'd1;
		end else begin
			res0      = sep_emit ? r_sep : r_eod;
			res0.last = !(sep_emit && end_of_data);
			res1      = r_eod;
			res1.last = 1'b1;
			res_cnt   = {1'b0, sep_emit} + {1'b0, end_of_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_START;
			esc_q <= 1'b0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			win_q <= '0;
			fmf_q <= '0;
			dfl_q <= '0;
		end else if (go) begin
			win_q <= win_n;
			if (dlm_hit || end_of_data) begin
				st_q  <= ST_START;
				esc_q <= 1'b0;
				pos_q <= '0;
				ovf_q <= 1'b0;
				fmf_q <= '0;
				dfl_q <= '0;
			end else begin
				st_q  <= st_n;
				esc_q <= esc_n;
				pos_q <= pos_inc;
				ovf_q <= ovf_inc;
				fmf_q <= fmf_n;
				dfl_q <= dfl_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/csvefs_outq.sv @@
`default_nettype none
module csvefs_outq
	import csvefs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire res_t                res0,
	input  wire res_t                res1,
	input  wire logic [1:0]          res_cnt,
	output logic                     room,
	output logic                     event_valid,
	input  wire logic                event_stall,
	output logic      [KIND_W-1:0]   event_kind,
	output logic      [OFFSET_W-1:0] offset,
	output logic                     offset_saturated,
	output logic                     run_last
);

	logic v0_q, v1_q;
	res_t d0_q, d1_q;
	logic take;

	assign take  = v0_q && !event_stall;
	assign room  = !v0_q || (take && !v1_q);

	assign event_valid      = v0_q;
	assign event_kind       = d0_q.kind;
	assign offset           = d0_q.offset;
	assign offset_saturated = d0_q.saturated;
	assign run_last         = d0_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (go) begin
			v0_q <= (res_cnt != 2'd0);
			v1_q <= (res_cnt == 2'd2);
		end else if (take) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			d0_q <= res0;
			d1_q <= res1;
		end else if (take) begin
			d0_q <= d1_q;
		end
	end

endmodule
`default_nettype wire

@@ src/csv_enclosed_field_splitter_top.sv @@
// Quoted CSV field splitter.
// Input channel: data_valid / data_stall carry one text byte (data_byte) per item,
// with end_of_data set on the final byte of the stream.
// Output channel: event_valid / event_stall carry one event per item: a column
// separator offset, a line length at a delimiter, or a trailing line length.
// run_last marks the last event caused by one byte; a byte causes 0 to 2 events.
// User must set patterns, quote, escape bytes via APB while idle; not enforced.
// A byte accepted into the input register passes the combinational parse step
// and is registered into the two-entry event buffer, which drives the event port.
// Throughput: one byte per cycle while the receiver does not stall; a byte with
// two events holds the input while the buffer drains.
// Reset clears the parser to line start, the window and counters to zero and
// the registers to comma, line feed, double quote and backslash.
// When the receiver stalls, the event on the port holds; data_stall rises once
// the input register holds a byte the buffer cannot take.
`default_nettype none
module csv_enclosed_field_splitter_top
	import csvefs_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 4,
	parameter int POSITION_BITS     = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic      [PDATA_W-1:0]  prdata,
	output logic                     pready,
	input  wire logic                data_valid,
	output logic                     data_stall,
	input  wire logic [7:0]          data_byte,
	input  wire logic                end_of_data,
	output logic                     event_valid,
	input  wire logic                event_stall,
	output logic      [KIND_W-1:0]   event_kind,
	output logic      [OFFSET_W-1:0] offset,
	output logic                     offset_saturated,
	output logic                     run_last
);

	cfg_t       cfg;
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;
	logic       room;
	logic       go;
	res_t       res0, res1;
	logic [1:0] res_cnt;

	assign go         = v_s1 && room;
	assign data_stall = v_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || go) begin
			v_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			eod_s1  <= end_of_data;
		end
	end

	csvefs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csvefs_core #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.POSITION_BITS     (POSITION_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.go          (go),
		.data_byte   (byte_s1),
		.end_of_data (eod_s1),
		.res0        (res0),
		.res1        (res1),
		.res_cnt     (res_cnt)
	);

	csvefs_outq u_outq (
		.clk              (clk),
		.arst_n           (arst_n),
		.go               (go),
		.res0             (res0),
		.res1             (res1),
		.res_cnt          (res_cnt),
		.room             (room),
		.event_valid      (event_valid),
		.event_stall      (event_stall),
		.event_kind       (event_kind),
		.offset           (offset),
		.offset_saturated (offset_saturated),
		.run_last         (run_last)
	);

endmodule
`default_nettype wire

@@ src/csvefs_chk.sv @@
`default_nettype none
module csvefs_chk
	import csvefs_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                event_valid,
	input wire logic                event_stall,
	input wire logic [KIND_W-1:0]   event_kind,
	input wire logic [OFFSET_W-1:0] offset,
	input wire logic                offset_saturated,
	input wire logic                run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid && $stable(event_kind) &&
			$stable(offset) && $stable(offset_saturated) && $stable(run_last))
		else $error("stalled event changed");

	a_line_alone: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == KIND_LINE |-> run_last)
		else $error("line event not last of its byte");

	a_trail_last: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == KIND_TRAIL |-> run_last)
		else $error("trailing line event not last of its byte");

	a_first_sep: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !run_last |-> event_kind == KIND_SEP)
		else $error("non-final event is not a separator");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !run_last && !event_stall |=> event_valid)
		else $error("second event of a byte missing");

endmodule

bind csv_enclosed_field_splitter_top csvefs_chk u_chk (.*);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import csvefs_pkg::*;

	typedef enum logic [2:0] {PS_START, PS_PLAIN, PS_QUOTED, PS_CLOSED, PS_SKIP} parse_state_t;

	typedef struct {
		logic [7:0] b;
		logic       eod;
	} text_byte_t;

	localparam int    PAT_MAX = 4;
	localparam longint POS_MAX = (64'd1 << 24) - 1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                data_valid = 1'b0;
	logic                data_stall;
	logic [7:0]          data_byte = 8'h00;
	logic                end_of_data = 1'b0;
	logic                event_valid;
	logic                event_stall = 1'b0;
	logic [KIND_W-1:0]   event_kind;
	logic [OFFSET_W-1:0] offset;
	logic                offset_saturated;
	logic                run_last;

	csv_enclosed_field_splitter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.data_valid(data_valid), .data_stall(data_stall),
		.data_byte(data_byte), .end_of_data(end_of_data),
		.event_valid(event_valid), .event_stall(event_stall),
		.event_kind(event_kind), .offset(offset),
		.offset_saturated(offset_saturated), .run_last(run_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// register copies
	logic [31:0] sep_pat = 32'd44;
	logic [2:0]  sep_len_reg = 3'd1;
	logic [31:0] dlm_pat = 32'd10;
	logic [2:0]  dlm_len_reg = 3'd1;
	logic [7:0]  quote_ch = 8'd34;
	logic [7:0]  esc_ch = 8'd92;

	// parser state
	parse_state_t pstate = PS_START;
	bit           in_escape = 1'b0;
	longint       line_pos = 0;
	logic [7:0]   win [PAT_MAX] = '{default: 8'h00};
	int           sep_fill = 0;
	int           dlm_fill = 0;
	bit           pos_sat = 1'b0;

	text_byte_t byte_queue[$];
	res_t       due_events[$];
	int         queued = 0;
	int         bytes_in = 0;
	int         events_seen = 0;
	int         errors = 0;
	int         settings = 1;
	bit         steady = 1'b0;
	int         hold_left = 0;
	bit         held_once = 1'b0;

	function automatic int pat_len(logic [2:0] r);
		if (r == 3'd0)
			return 1;
		if (r > PAT_MAX)
			return PAT_MAX;
		return r;
	endfunction

	function automatic bit window_hit(logic [31:0] pat, int len);
		int k;
		for (k = 0; k < len; k++)
			if (win[len-1-k] != pat[8*k +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic fresh_line();
		pstate = PS_START;
		in_escape = 1'b0;
		line_pos = 0;
		sep_fill = 0;
		dlm_fill = 0;
		pos_sat = 1'b0;
	endtask

	task automatic add_event(logic [KIND_W-1:0] kind, longint v);
		res_t r;
		bit sat;
		sat = pos_sat;
		if (v > POS_MAX) begin
			v = POS_MAX;
			sat = 1'b1;
		end
		if (v > longint'(OFFSET_MAX)) begin
			v = longint'(OFFSET_MAX);
			sat = 1'b1;
		end
		r.kind = kind;
		r.offset = v[OFFSET_W-1:0];
		r.saturated = sat;
		r.last = 1'b0;
		due_events.insert(due_events.size(), r);
	endtask

	task automatic scan_byte(logic [7:0] b, logic eod);
		int slen;
		int dlen;
		int n0;
		int i;
		longint p;
		slen = pat_len(sep_len_reg);
		dlen = pat_len(dlm_len_reg);
		n0 = due_events.size();
		p = line_pos;
		for (i = PAT_MAX - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = b;
		if (sep_fill < PAT_MAX)
			sep_fill++;
		if (dlm_fill < PAT_MAX)
			dlm_fill++;

		if (pstate != PS_QUOTED && dlm_fill >= dlen && window_hit(dlm_pat, dlen)) begin
			add_event(KIND_LINE, p + 1 - dlen);
			fresh_line();
			due_events[due_events.size()-1].last = 1'b1;
			return;
		end

		if (pstate == PS_START) begin
			if (b == quote_ch) begin
				pstate = PS_QUOTED;
				in_escape = 1'b0;
			end else begin
				pstate = PS_PLAIN;
			end
		end else if (pstate == PS_QUOTED) begin
			if (b == esc_ch) begin
				in_escape = !in_escape;
			end else if (in_escape) begin
				in_escape = 1'b0;
			end else if (b == quote_ch) begin
				pstate = PS_CLOSED;
				sep_fill = 0;
				dlm_fill = 0;
			end
		end else if (pstate == PS_CLOSED) begin
			if (sep_fill >= slen) begin
				if (window_hit(sep_pat, slen)) begin
					add_event(KIND_SEP, p + 1 - slen);
					sep_fill = 0;
					pstate = PS_START;
				end else begin
					pstate = PS_SKIP;
				end
			end
		end else if (pstate != PS_PLAIN) begin
			pstate = PS_SKIP;
		end

		if (pstate == PS_PLAIN && sep_fill >= slen && window_hit(sep_pat, slen)) begin
			add_event(KIND_SEP, p + 1 - slen);
			sep_fill = 0;
			pstate = PS_START;
		end

		if (line_pos >= POS_MAX) begin
			line_pos = POS_MAX;
			pos_sat = 1'b1;
		end else begin
			line_pos++;
		end

		if (eod) begin
			add_event(KIND_TRAIL, line_pos);
			fresh_line();
		end

		if (due_events.size() > n0)
			due_events[due_events.size()-1].last = 1'b1;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		text_byte_t cur;
		if (!arst_n) begin
			data_valid <= 1'b0;
		end else begin
			if (data_valid && !data_stall) begin
				scan_byte(data_byte, end_of_data);
				bytes_in <= bytes_in + 1;
			end
			if (!data_valid || !data_stall) begin
				if (byte_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
					cur = byte_queue.pop_front();
					data_valid <= 1'b1;
					data_byte <= cur.b;
					end_of_data <= cur.eod;
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			event_stall <= 1'b0;
		end else begin
			if (event_valid && !event_stall) begin
				if (due_events.size() == 0) begin
					$display("%0t: unexpected event, expected none, got kind %0d offset %0d",
						$time, event_kind, offset);
					errors++;
				end else begin
					want = due_events.pop_front();
					compare_field("event_kind", want.kind, event_kind);
					compare_field("offset", want.offset, offset);
					compare_field("offset_saturated", want.saturated, offset_saturated);
					compare_field("run_last", want.last, run_last);
				end
				events_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				event_stall <= 1'b1;
			end else if (!held_once && bytes_in >= 60) begin
				held_once = 1'b1;
				hold_left = 300;
				event_stall <= 1'b1;
			end else begin
				event_stall <= !steady && ($urandom_range(0, 99) < 11);
			end
		end
	end

	task automatic push_byte(logic [7:0] b, logic eod);
		text_byte_t t;
		t.b = b;
		t.eod = eod;
		byte_queue.insert(byte_queue.size(), t);
		queued++;
	endtask

	task automatic push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	task automatic push_pattern(logic [31:0] pat, logic [2:0] r);
		int k;
		for (k = 0; k < pat_len(r); k++)
			push_byte(pat[8*k +: 8], 1'b0);
	endtask

	function automatic logic [7:0] special_byte();
		int k;
		k = $urandom_range(0, 3);
		case ($urandom_range(0, 5))
			0: return sep_pat[8*k +: 8];
			1: return dlm_pat[8*k +: 8];
			2: return quote_ch;
			3: return esc_ch;
			4: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h61, 8'h7a));
		endcase
	endfunction

	task automatic quoted_body();
		int j;
		for (j = $urandom_range(0, 5); j > 0; j--)
			case ($urandom_range(0, 4))
				0: push_pattern(sep_pat, sep_len_reg);
				1: push_pattern(dlm_pat, dlm_len_reg);
				2: begin
					push_byte(esc_ch, 1'b0);
					push_byte(special_byte(), 1'b0);
				end
				default: push_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
			endcase
	endtask

	task automatic random_text(int count);
		int stop;
		int f;
		int j;
		stop = queued + count;
		while (queued < stop) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					case ($urandom_range(0, 2))
						0: begin
							push_byte(quote_ch, 1'b0);
							quoted_body();
							push_byte(quote_ch, 1'b0);
							for (j = $urandom_range(1, 3); j > 0; j--)
								push_byte(special_byte(), 1'b0);
						end
						1: begin
							push_byte(quote_ch, 1'b0);
							quoted_body();
						end
						default: begin
							push_byte(sep_pat[7:0], 1'b0);
							push_byte(special_byte(), 1'b0);
						end
					endcase
					push_pattern(dlm_pat, dlm_len_reg);
				end
				3, 4: begin
					for (j = $urandom_range(1, 8); j > 0; j--)
						push_byte($urandom_range(0, 1) ? special_byte() : 8'($urandom),
							$urandom_range(0, 99) < 3);
				end
				default: begin
					for (f = $urandom_range(1, 4); f > 0; f--) begin
						if ($urandom_range(0, 9) < 4) begin
							push_byte(quote_ch, 1'b0);
							quoted_body();
							push_byte(quote_ch, 1'b0);
						end else begin
							for (j = $urandom_range(0, 5); j > 0; j--)
								push_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
						end
						if (f > 1)
							push_pattern(sep_pat, sep_len_reg);
					end
					push_pattern(dlm_pat, dlm_len_reg);
					if ($urandom_range(0, 99) < 5)
						byte_queue[byte_queue.size()-1].eod = 1'b1;
				end
			endcase
		end
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COL_SEP_BYTES:  sep_pat = val;
			REG_COL_SEP_LENGTH: sep_len_reg = val[2:0];
			REG_LINE_DLM_BYTES: dlm_pat = val;
			REG_LINE_DLM_LEN:   dlm_len_reg = val[2:0];
			REG_ENCLOSE_CHAR:   quote_ch = val[7:0];
			REG_ESCAPE_CHAR:    esc_ch = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] sp, logic [2:0] sl, logic [31:0] dp,
			logic [2:0] dl, logic [7:0] q, logic [7:0] e);
		write_reg(REG_COL_SEP_BYTES, sp);
		write_reg(REG_COL_SEP_LENGTH, 32'(sl));
		write_reg(REG_LINE_DLM_BYTES, dp);
		write_reg(REG_LINE_DLM_LEN, 32'(dl));
		write_reg(REG_ENCLOSE_CHAR, 32'(q));
		write_reg(REG_ESCAPE_CHAR, 32'(e));
		settings++;
	endtask

	task automatic drain();
		while (bytes_in != queued || due_events.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_text("a,b\n");
		push_text("\"x,\n\\\"y\",z\n");
		push_text("\"q\"z\n");
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte("\n", 1'b1);
		push_byte("c", 1'b1);
		push_text("\"op");
		push_byte(",", 1'b1);
		random_text(130);
		drain();

		// escape equal to enclose
		set_config(32'h0000_7c3b, 3'd2, 32'h0000_0a0d, 3'd2, 8'h27, 8'h27);
		push_text("'a''b';|x\r\n");
		push_byte("z", 1'b1);
		random_text(130);
		drain();

		steady = 1'b1;
		set_config(32'hffff_ffff, 3'd7, 32'h0000_0000, 3'd0, 8'hff, 8'h00);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		random_text(130);
		drain();
		steady = 1'b0;

		// delimiter sharing its last byte with the separator
		set_config(32'h0000_002c, 3'd1, 32'h0000_2c22, 3'd2, 8'h22, 8'h5c);
		push_text("\"ab\",x\",y");
		push_byte("\n", 1'b1);
		random_text(130);
		drain();

		set_config($urandom, 3'($urandom_range(0, 7)), $urandom, 3'($urandom_range(0, 7)),
			8'($urandom), 8'($urandom));
		random_text(130);
		drain();

		set_config(32'h002d_2d3c, 3'd3, 32'h0a44_4e45, 3'd4, 8'h22, 8'h5c);
		random_text(130);
		drain();
		repeat (10) @(posedge clk);

		$display("Checked %0d events caused by %0d bytes under %0d register settings,",
			events_seen, bytes_in, settings);
		$display("with random gaps on both sides and one long hold on the event output.");
		if (errors == 0 && due_events.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(12 * 300000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
